// ===== sv/sie_pkg.sv =====
// Shared types and constants for the SH irradiance evaluator.
package sie_pkg;

   localparam int NUM_BASIS  = 9;
   localparam int FRAC_BITS  = 32;
   localparam int TABLE_SIZE = NUM_BASIS * 3;

   // Q32.32 basis scale factors
   localparam logic [63:0] FIX_ONE = 64'd4294967296;
   localparam logic [63:0] K_SH0   = 64'd1207959552;
   localparam logic [63:0] K_L1    = 64'd2090139136;
   localparam logic [63:0] K_L1N   = 64'(-64'sd2090139136);
   localparam logic [63:0] K_L2    = 64'd4685362176;
   localparam logic [63:0] K_L2N   = 64'(-64'sd4685362176);
   localparam logic [63:0] K_L20   = 64'd1355170304;
   localparam logic [63:0] K_L22   = 64'd2342681088;
   localparam logic [32:0] THR_RESET = 33'd429496730;

   // request kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_PROD, S_MAC_RD, S_MAC, S_SQ, S_SQRT, S_DIV, S_SCALE, S_OUT
   } state_type;

   // handshake between sequencer and an iterative unit
   typedef struct packed {
      logic start;
   } unit_req_type;

endpackage

// ===== sv/sie_mul.sv =====
// Iterative signed Q32.32 multiplier: four 33x33 partial products.
module sie_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  sie_pkg::unit_req_type ctl,
   input  logic [63:0]           a,
   input  logic [63:0]           b,
   output logic                  busy,
   output logic                  done,
   output logic [63:0]           result
);
   logic [63:0] a_ff, b_ff;
   logic [95:0] acc_ff, acc_in;
   logic signed [65:0] prod_ff;
   logic [2:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic signed [32:0] oa, ob;
   logic [95:0] pext;
   logic [1:0]  prev;

   // operand halves: low half unsigned, high half signed
   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin oa = {1'b0, a_ff[31:0]};  ob = {1'b0, b_ff[31:0]};  end
         2'd1: begin oa = {1'b0, a_ff[31:0]};  ob = {b_ff[63], b_ff[63:32]}; end
         2'd2: begin oa = {a_ff[63], a_ff[63:32]}; ob = {1'b0, b_ff[31:0]}; end
         default: begin oa = {a_ff[63], a_ff[63:32]}; ob = {b_ff[63], b_ff[63:32]}; end
      endcase
   end

   // align the previous partial product
   always_comb begin
      prev = 2'(cnt_ff - 3'd1);
      pext = {{30{prod_ff[65]}}, prod_ff};
      case (prev)
         2'd0:    acc_in = acc_ff + pext;
         2'd3:    acc_in = acc_ff + (pext << 64);
         default: acc_in = acc_ff + (pext << 32);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start && !busy_ff) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff != 3'd4) prod_ff <= oa * ob;
         if (cnt_ff != 3'd0) acc_ff <= acc_in;
      end
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = acc_ff[95:32];
endmodule

// ===== sv/sie_sqrt.sv =====
// Bit-serial floor square root of (sum << 32), one root bit per cycle.
module sie_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  sie_pkg::unit_req_type ctl,
   input  logic [63:0]           sum,
   output logic                  done,
   output logic [47:0]           root
);
   logic [95:0] rad_ff;
   logic [51:0] rem_ff, remx, trial;
   logic [47:0] root_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff, ge;

   // one restoring step
   always_comb begin
      remx  = {rem_ff[49:0], rad_ff[95:94]};
      trial = {2'b00, root_ff, 2'b01};
      ge    = remx >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start && !busy_ff) begin
         rad_ff  <= {sum, 32'd0};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= ge ? remx - trial : remx;
         root_ff <= {root_ff[46:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== sv/sie_div.sv =====
// Bit-serial divider: (mag << 32) / len, quotient kept to 64 bits.
module sie_div (
   input  logic                  clock,
   input  logic                  reset,
   input  sie_pkg::unit_req_type ctl,
   input  logic [63:0]           mag,
   input  logic [32:0]           len,
   output logic                  done,
   output logic [63:0]           quot
);
   logic [63:0] dvd_ff, q_ff;
   logic [33:0] rem_ff, remx;
   logic [32:0] len_ff;
   logic [6:0]  cnt_ff;
   logic        busy_ff, done_ff, ge;

   always_comb begin
      remx = {rem_ff[32:0], dvd_ff[63]};
      ge   = remx >= {1'b0, len_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd95) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // 64 dividend bits then 32 zero bits
   always_ff @(posedge clock) begin
      if (ctl.start && !busy_ff) begin
         dvd_ff <= mag;
         len_ff <= len;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= ge ? remx - {1'b0, len_ff} : remx;
         q_ff   <= {q_ff[62:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ===== sv/sh_irradiance_evaluate_core.sv =====
// Top level: SH L2 irradiance evaluator with sequencer and shared units.
// A load beat (tuser 0) writes one coefficient. An evaluate beat (tuser 1)
// runs through one shared 64x64 multiplier (issue, busy, done for each
// product): 14 products for the basis, 27 multiply-accumulates (each with the
// coefficient memory read), 3 squares, then a square root. A negative sum of
// squares skips the square root. When the rescale applies, each channel adds a
// divide and one product. The result beat is held until taken; no new request
// is accepted meanwhile.
module sh_irradiance_evaluate_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // coeff_index[4:0], coeff_value[68:5], normal_x[102:69],
   // normal_y[136:103], normal_z[170:137], zero fill
   input  logic [175:0]  req_tdata,
   // kind
   input  logic [0:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // irradiance_red[63:0], irradiance_green[127:64], irradiance_blue[191:128]
   output logic [191:0]  rsp_tdata,
   // was_rescaled
   output logic [0:0]    rsp_tuser,
   input  logic          csr_wr_en,
   input  logic [32:0]   csr_wr_data
);
   sie_pkg::state_type state_ff, state_in;

   logic [32:0] thr_ff;
   logic [63:0] x_ff, y_ff, z_ff;
   logic [63:0] tmp_ff [6];
   logic [63:0] sh_ff  [9];
   logic [63:0] irr_ff [3];
   logic [63:0] coef_mem [sie_pkg::TABLE_SIZE];
   logic [63:0] coef_rd_ff, sum_ff, q_ff;
   logic [47:0] len_ff;
   logic [3:0]  cnt_ff, basis_ff;
   logic [4:0]  mac_ff;
   logic [1:0]  ch_ff;
   logic        issued_ff, resc_ff;

   logic        req_acc, rsp_acc;
   logic [4:0]  req_idx;
   sie_pkg::unit_req_type mul_req, sqrt_req, div_req;
   logic [63:0] mul_a, mul_b, mul_res, sum_next, div_mag, div_q, q_signed;
   logic        mul_busy, mul_done, sqrt_done, div_done, do_resc;
   logic [47:0] sqrt_root;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign req_idx = req_tdata[4:0];
   assign sum_next = sum_ff + mul_res;
   assign do_resc  = (sqrt_root != '0) && ({15'd0, thr_ff} > sqrt_root);
   assign div_mag  = irr_ff[ch_ff][63] ? 64'(-irr_ff[ch_ff]) : irr_ff[ch_ff];
   assign q_signed = irr_ff[ch_ff][63] ? 64'(-div_q) : div_q;

   // shared units
   sie_mul u_mul (.clock, .reset, .ctl(mul_req), .a(mul_a), .b(mul_b),
                  .busy(mul_busy), .done(mul_done), .result(mul_res));
   sie_sqrt u_sqrt (.clock, .reset, .ctl(sqrt_req), .sum(sum_ff),
                    .done(sqrt_done), .root(sqrt_root));
   sie_div u_div (.clock, .reset, .ctl(div_req), .mag(div_mag),
                  .len(len_ff[32:0]), .done(div_done), .quot(div_q));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sie_pkg::S_IDLE:
            if (req_acc && req_tuser[0] == sie_pkg::KIND_EVAL) state_in = sie_pkg::S_PROD;
         sie_pkg::S_PROD:
            if (mul_done && cnt_ff == 4'd13) state_in = sie_pkg::S_MAC_RD;
         sie_pkg::S_MAC_RD: state_in = sie_pkg::S_MAC;
         sie_pkg::S_MAC:
            if (mul_done) begin
               state_in = (mac_ff == 5'(sie_pkg::TABLE_SIZE - 1)) ? sie_pkg::S_SQ
                                                                  : sie_pkg::S_MAC_RD;
            end
         sie_pkg::S_SQ:
            if (mul_done && ch_ff == 2'd2) begin
               state_in = sum_next[63] ? sie_pkg::S_OUT : sie_pkg::S_SQRT;
            end
         sie_pkg::S_SQRT:
            if (sqrt_done) state_in = do_resc ? sie_pkg::S_DIV : sie_pkg::S_OUT;
         sie_pkg::S_DIV:
            if (div_done) state_in = sie_pkg::S_SCALE;
         sie_pkg::S_SCALE:
            if (mul_done) state_in = (ch_ff == 2'd2) ? sie_pkg::S_OUT : sie_pkg::S_DIV;
         sie_pkg::S_OUT:
            if (rsp_acc) state_in = sie_pkg::S_IDLE;
         default: state_in = sie_pkg::S_IDLE;
      endcase
   end

   // unit starts and multiplier operand select
   always_comb begin
      mul_req.start  = 1'b0;
      sqrt_req.start = 1'b0;
      div_req.start  = 1'b0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         sie_pkg::S_PROD: begin
            mul_req.start = !issued_ff;
            case (cnt_ff)
               4'd0:  begin mul_a = x_ff; mul_b = y_ff; end
               4'd1:  begin mul_a = y_ff; mul_b = z_ff; end
               4'd2:  begin mul_a = x_ff; mul_b = z_ff; end
               4'd3:  begin mul_a = z_ff; mul_b = z_ff; end
               4'd4:  begin mul_a = x_ff; mul_b = x_ff; end
               4'd5:  begin mul_a = y_ff; mul_b = y_ff; end
               4'd6:  begin mul_a = sie_pkg::K_L1N; mul_b = y_ff; end
               4'd7:  begin mul_a = sie_pkg::K_L1;  mul_b = z_ff; end
               4'd8:  begin mul_a = sie_pkg::K_L1N; mul_b = x_ff; end
               4'd9:  begin mul_a = sie_pkg::K_L2;  mul_b = tmp_ff[0]; end
               4'd10: begin mul_a = sie_pkg::K_L2N; mul_b = tmp_ff[1]; end
               4'd11: begin
                  mul_a = sie_pkg::K_L20;
                  mul_b = tmp_ff[3] + (tmp_ff[3] << 1) - sie_pkg::FIX_ONE;
               end
               4'd12: begin mul_a = sie_pkg::K_L2N; mul_b = tmp_ff[2]; end
               4'd13: begin mul_a = sie_pkg::K_L22; mul_b = tmp_ff[4] - tmp_ff[5]; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         sie_pkg::S_MAC: begin
            mul_req.start = !issued_ff;
            mul_a = coef_rd_ff;
            mul_b = sh_ff[basis_ff];
         end
         sie_pkg::S_SQ: begin
            mul_req.start = !issued_ff;
            mul_a = irr_ff[ch_ff];
            mul_b = irr_ff[ch_ff];
         end
         sie_pkg::S_SQRT: sqrt_req.start = !issued_ff;
         sie_pkg::S_DIV:  div_req.start  = !issued_ff;
         sie_pkg::S_SCALE: begin
            mul_req.start = !issued_ff;
            mul_a = q_ff;
            mul_b = {31'd0, thr_ff};
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sie_pkg::S_IDLE;
         thr_ff    <= sie_pkg::THR_RESET;
         issued_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) thr_ff <= csr_wr_data;
         if (mul_req.start || sqrt_req.start || div_req.start) issued_ff <= 1'b1;
         else if (mul_done || sqrt_done || div_done) issued_ff <= 1'b0;
      end
   end

   // coefficient memory
   always_ff @(posedge clock) begin
      if (req_acc && req_tuser[0] == sie_pkg::KIND_LOAD &&
          req_idx < 5'(sie_pkg::TABLE_SIZE)) begin
         coef_mem[req_idx] <= req_tdata[68:5];
      end
      coef_rd_ff <= coef_mem[mac_ff];
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         sie_pkg::S_IDLE:
            if (req_acc) begin
               x_ff <= {{30{req_tdata[102]}}, req_tdata[102:69]};
               y_ff <= {{30{req_tdata[136]}}, req_tdata[136:103]};
               z_ff <= {{30{req_tdata[170]}}, req_tdata[170:137]};
               sh_ff[0] <= sie_pkg::K_SH0;
               for (int c = 0; c < 3; c++) irr_ff[c] <= '0;
               sum_ff   <= '0;
               len_ff   <= '0;
               cnt_ff   <= '0;
               mac_ff   <= '0;
               basis_ff <= '0;
               ch_ff    <= '0;
               resc_ff  <= 1'b0;
            end
         sie_pkg::S_PROD:
            if (mul_done) begin
               if (cnt_ff < 4'd6) tmp_ff[cnt_ff[2:0]] <= mul_res;
               else sh_ff[4'(cnt_ff - 4'd5)] <= mul_res;
               cnt_ff <= cnt_ff + 4'd1;
            end
         sie_pkg::S_MAC:
            if (mul_done) begin
               irr_ff[ch_ff] <= irr_ff[ch_ff] + mul_res;
               mac_ff <= mac_ff + 5'd1;
               if (ch_ff == 2'd2) begin
                  ch_ff    <= '0;
                  basis_ff <= basis_ff + 4'd1;
               end else begin
                  ch_ff <= ch_ff + 2'd1;
               end
            end
         sie_pkg::S_SQ:
            if (mul_done) begin
               sum_ff <= sum_next;
               ch_ff  <= (ch_ff == 2'd2) ? 2'd0 : ch_ff + 2'd1;
            end
         sie_pkg::S_SQRT:
            if (sqrt_done) begin
               len_ff  <= sqrt_root;
               resc_ff <= do_resc;
            end
         sie_pkg::S_DIV:
            if (div_done) q_ff <= q_signed;
         sie_pkg::S_SCALE:
            if (mul_done) begin
               irr_ff[ch_ff] <= mul_res;
               ch_ff <= ch_ff + 2'd1;
            end
         default: ;
      endcase
   end

   // ports
   assign req_tready   = state_ff == sie_pkg::S_IDLE;
   assign rsp_tvalid   = state_ff == sie_pkg::S_OUT;
   assign rsp_tdata    = {irr_ff[2], irr_ff[1], irr_ff[0]};
   assign rsp_tuser[0] = resc_ff;

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and result both open");
   a_resc_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> len_ff != '0 && {15'd0, thr_ff} > len_ff)
      else $error("rescale flag without short nonzero length");
   a_mul_start: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !mul_busy)
      else $error("multiplier started while busy");
endmodule
